// ----- rtl/blocked_array_address_unit_core_macros.svh -----
// Assertion helpers shared by the address unit files.
`ifndef BLOCKED_ARRAY_ADDRESS_UNIT_CORE_MACROS_SVH
`define BLOCKED_ARRAY_ADDRESS_UNIT_CORE_MACROS_SVH

// Clocked check, held off while reset is high.
`define BAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that holds through reset as well.
`define BAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/bau_pkg.sv -----
package bau_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int MAX_BLOCK  = 256;

   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int BLOCK_W    = 9;
   localparam int CELL_W     = 16;
   localparam int OFFS_W     = $clog2(MAX_BLOCK);
   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int DIV_STEPS  = COORD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   typedef logic [FUNC_W-1:0]     func_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam func_type FUNC_TRANSLATE = func_type'(0);
   localparam func_type FUNC_NEXT      = func_type'(1);
   localparam func_type FUNC_RESTART   = func_type'(2);

   localparam status_type STATUS_OK    = status_type'(0);
   localparam status_type STATUS_RANGE = status_type'(1);
   localparam status_type STATUS_DONE  = status_type'(2);

   localparam csr_addr_type REG_ARRAY_WIDTH  = csr_addr_type'(0);
   localparam csr_addr_type REG_ARRAY_HEIGHT = csr_addr_type'(1);
   localparam csr_addr_type REG_BLOCK_SIZE   = csr_addr_type'(2);

   // Effective array geometry after clamping
   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [BLOCK_W-1:0] bsize;
   } geom_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quotient;
      logic [BLOCK_W-1:0] remainder;
   } div_result_type;

   typedef struct packed {
      logic               done;
      logic               last_on_step;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] block_col;
      logic [COORD_W-1:0] block_row;
      logic [CELL_W-1:0]  cell_idx;
   } walk_pos_type;

   typedef struct packed {
      status_type         status;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] block_col;
      logic [COORD_W-1:0] block_row;
      logic [CELL_W-1:0]  cell_idx;
      logic               last;
   } result_type;

   // Clamp an array dimension to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   // Clamp the block side to 1..MAX_BLOCK
   function automatic logic [BLOCK_W-1:0] eff_block(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = BLOCK_W'(1);
      end else if (v > BLOCK_W'(MAX_BLOCK)) begin
         r = BLOCK_W'(MAX_BLOCK);
      end
      return r;
   endfunction

endpackage

// ----- rtl/bau_divider.sv -----
`include "blocked_array_address_unit_core_macros.svh"

// Restoring divider, one quotient bit per cycle.
module bau_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bau_pkg::COORD_W-1:0]  dividend,
   input  logic [bau_pkg::BLOCK_W-1:0]  divisor,
   output bau_pkg::div_result_type      result
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bau_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic [bau_pkg::COORD_W-1:0]   quot_ff, quot_in;
   logic [bau_pkg::BLOCK_W-1:0]   rem_ff, rem_in;
   logic [bau_pkg::BLOCK_W:0]     shifted;
   logic [bau_pkg::BLOCK_W:0]     diff;
   logic                          fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      shifted = {rem_ff, quot_ff[bau_pkg::COORD_W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = bau_pkg::DIV_CNT_W'(bau_pkg::DIV_STEPS);
         quot_in  = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[bau_pkg::COORD_W-2:0], fits};
         rem_in   = fits ? diff[bau_pkg::BLOCK_W-1:0] : shifted[bau_pkg::BLOCK_W-1:0];
         count_in = count_ff - bau_pkg::DIV_CNT_W'(1);
         if (count_ff == bau_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quot_ff;
   assign result.remainder = rem_ff;

   `BAU_ASSERT(a_div_no_restart, clock, reset, start |-> !busy_ff, "divider started while busy")
   `BAU_ASSERT(a_div_rem_bound, clock, reset, done_ff |-> (rem_ff < divisor), "remainder not below divisor")

endmodule

// ----- rtl/bau_walker.sv -----
`include "blocked_array_address_unit_core_macros.svh"

// Walk position in block order: blocks column by column, cells column-major.
module bau_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic                  step,
   input  bau_pkg::geom_type     geom,
   output bau_pkg::walk_pos_type pos
);

   logic [bau_pkg::COORD_W-1:0] bcol_ff, bcol_in;
   logic [bau_pkg::COORD_W-1:0] brow_ff, brow_in;
   logic [bau_pkg::DIM_W-1:0]   base_col_ff, base_col_in;
   logic [bau_pkg::DIM_W-1:0]   base_row_ff, base_row_in;
   logic [bau_pkg::OFFS_W-1:0]  ic_ff, ic_in;
   logic [bau_pkg::OFFS_W-1:0]  ir_ff, ir_in;
   logic [bau_pkg::CELL_W-1:0]  ic_base_ff, ic_base_in;
   logic [bau_pkg::CELL_W-1:0]  cell_ff, cell_in;
   logic                        done_ff, done_in;

   logic [bau_pkg::BLOCK_W-1:0] ic_nxt, ir_nxt;
   logic                        row_more, col_more, brow_more, bcol_more;

   // Decide where the next cell inside the array lies
   always_comb begin
      ic_nxt    = {1'b0, ic_ff} + bau_pkg::BLOCK_W'(1);
      ir_nxt    = {1'b0, ir_ff} + bau_pkg::BLOCK_W'(1);
      row_more  = (ir_nxt < geom.bsize) &&
                  (({1'b0, base_row_ff} + (bau_pkg::DIM_W+1)'(ir_nxt)) < {1'b0, geom.height});
      col_more  = (ic_nxt < geom.bsize) &&
                  (({1'b0, base_col_ff} + (bau_pkg::DIM_W+1)'(ic_nxt)) < {1'b0, geom.width});
      brow_more = ({1'b0, base_row_ff} + (bau_pkg::DIM_W+1)'(geom.bsize)) < {1'b0, geom.height};
      bcol_more = ({1'b0, base_col_ff} + (bau_pkg::DIM_W+1)'(geom.bsize)) < {1'b0, geom.width};
   end

   always_comb begin
      bcol_in     = bcol_ff;
      brow_in     = brow_ff;
      base_col_in = base_col_ff;
      base_row_in = base_row_ff;
      ic_in       = ic_ff;
      ir_in       = ir_ff;
      ic_base_in  = ic_base_ff;
      cell_in     = cell_ff;
      done_in     = done_ff;
      priority if (restart) begin
         bcol_in     = '0;
         brow_in     = '0;
         base_col_in = '0;
         base_row_in = '0;
         ic_in       = '0;
         ir_in       = '0;
         ic_base_in  = '0;
         cell_in     = '0;
         done_in     = 1'b0;
      end else if (step) begin
         priority if (row_more) begin
            ir_in   = ir_nxt[bau_pkg::OFFS_W-1:0];
            cell_in = cell_ff + bau_pkg::CELL_W'(1);
         end else if (col_more) begin
            ic_in      = ic_nxt[bau_pkg::OFFS_W-1:0];
            ir_in      = '0;
            ic_base_in = ic_base_ff + bau_pkg::CELL_W'(geom.bsize);
            cell_in    = ic_base_ff + bau_pkg::CELL_W'(geom.bsize);
         end else begin
            ic_in      = '0;
            ir_in      = '0;
            ic_base_in = '0;
            cell_in    = '0;
            if (brow_more) begin
               brow_in     = brow_ff + bau_pkg::COORD_W'(1);
               base_row_in = base_row_ff + bau_pkg::DIM_W'(geom.bsize);
            end else begin
               brow_in     = '0;
               base_row_in = '0;
               if (bcol_more) begin
                  bcol_in     = bcol_ff + bau_pkg::COORD_W'(1);
                  base_col_in = base_col_ff + bau_pkg::DIM_W'(geom.bsize);
               end else begin
                  bcol_in     = '0;
                  base_col_in = '0;
                  done_in     = 1'b1;
               end
            end
         end
      end else begin
         done_in = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcol_ff     <= '0;
         brow_ff     <= '0;
         base_col_ff <= '0;
         base_row_ff <= '0;
         ic_ff       <= '0;
         ir_ff       <= '0;
         ic_base_ff  <= '0;
         cell_ff     <= '0;
         done_ff     <= 1'b0;
      end else begin
         bcol_ff     <= bcol_in;
         brow_ff     <= brow_in;
         base_col_ff <= base_col_in;
         base_row_ff <= base_row_in;
         ic_ff       <= ic_in;
         ir_ff       <= ir_in;
         ic_base_ff  <= ic_base_in;
         cell_ff     <= cell_in;
         done_ff     <= done_in;
      end
   end

   assign pos.done         = done_ff;
   assign pos.last_on_step = !row_more && !col_more && !brow_more && !bcol_more;
   assign pos.col          = bau_pkg::COORD_W'(base_col_ff + bau_pkg::DIM_W'(ic_ff));
   assign pos.row          = bau_pkg::COORD_W'(base_row_ff + bau_pkg::DIM_W'(ir_ff));
   assign pos.block_col    = bcol_ff;
   assign pos.block_row    = brow_ff;
   assign pos.cell_idx     = cell_ff;

   `BAU_ASSERT(a_walk_inside, clock, reset, !done_ff |-> (((base_col_ff + bau_pkg::DIM_W'(ic_ff)) < geom.width) && ((base_row_ff + bau_pkg::DIM_W'(ir_ff)) < geom.height)), "walk position outside the array")

endmodule

// ----- rtl/blocked_array_address_unit_core.sv -----
// Address unit for a blocked 2D array. A translate word (tuser 0) maps a
// column and row to block column, block row and the column-major cell index
// inside the block, or reports out-of-range; a next word (tuser 1) emits the
// current walk cell and advances the walk; a restart word (tuser 2) rewinds
// the walk; tuser 3 is dropped with no response. One word is in flight at a
// time. In a translate the column and then the row go through one shared
// bit-serial divider of 12 steps each, followed by a multiply-add state for
// the cell index. Next, restart and an out-of-range translate pass through
// the finish state to the response register; a dropped word leaves the input
// ready. The user must write registers through the csr port only while idle;
// the block does not enforce it. Any write of a known register rewinds the walk.
`include "blocked_array_address_unit_core_macros.svh"

module blocked_array_address_unit_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // col[11:0], row[23:12]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // col_out, row_out, block_col, block_row, cell_index
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,   // last
   // register write port
   input  logic        csr_we,
   input  logic [bau_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bau_pkg::DIM_W-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_COL,
      ST_DIV_ROW,
      ST_MAC,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [bau_pkg::DIM_W-1:0]   width_ff, width_in;
   logic [bau_pkg::DIM_W-1:0]   height_ff, height_in;
   logic [bau_pkg::BLOCK_W-1:0] bsize_ff, bsize_in;
   bau_pkg::geom_type           geom;

   bau_pkg::result_type         res_ff, res_in;
   bau_pkg::result_type         rsp_res_ff, rsp_res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bau_pkg::COORD_W-1:0] row_hold_ff, row_hold_in;
   logic [bau_pkg::BLOCK_W-1:0] rcol_ff, rcol_in;
   logic [bau_pkg::BLOCK_W-1:0] rrow_ff, rrow_in;

   logic                        accept;
   bau_pkg::func_type           func;
   logic [bau_pkg::COORD_W-1:0] req_col, req_row;
   logic                        in_range;
   logic                        cfg_hit;
   logic                        walk_restart, walk_step;
   logic                        div_start;
   logic [bau_pkg::COORD_W-1:0] div_dividend;
   logic [2*bau_pkg::BLOCK_W-1:0] cell_sum;
   bau_pkg::div_result_type     div_res;
   bau_pkg::walk_pos_type       pos;

   // Unpack the request word
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign func       = req_tuser;
   assign req_col    = req_tdata[11:0];
   assign req_row    = req_tdata[23:12];

   // Clamp the programmed geometry
   assign geom.width  = bau_pkg::eff_dim(width_ff);
   assign geom.height = bau_pkg::eff_dim(height_ff);
   assign geom.bsize  = bau_pkg::eff_block(bsize_ff);

   assign in_range = ({1'b0, req_col} < geom.width) && ({1'b0, req_row} < geom.height);

   // Register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bsize_in  = bsize_ff;
      cfg_hit   = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            bau_pkg::REG_ARRAY_WIDTH: begin
               width_in = csr_wdata;
               cfg_hit  = 1'b1;
            end
            bau_pkg::REG_ARRAY_HEIGHT: begin
               height_in = csr_wdata;
               cfg_hit   = 1'b1;
            end
            bau_pkg::REG_BLOCK_SIZE: begin
               bsize_in = csr_wdata[bau_pkg::BLOCK_W-1:0];
               cfg_hit  = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   assign walk_restart = cfg_hit || (accept && (func == bau_pkg::FUNC_RESTART));
   assign walk_step    = accept && (func == bau_pkg::FUNC_NEXT) && !pos.done;
   assign div_dividend = (state_ff == ST_IDLE) ? req_col : row_hold_ff;
   assign cell_sum     = ((2*bau_pkg::BLOCK_W)'(geom.bsize) * (2*bau_pkg::BLOCK_W)'(rcol_ff))
                         + (2*bau_pkg::BLOCK_W)'(rrow_ff);

   bau_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (geom.bsize),
      .result   (div_res)
   );

   bau_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .restart (walk_restart),
      .step    (walk_step),
      .geom    (geom),
      .pos     (pos)
   );

   // Sequence one request through to the response register
   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      row_hold_in  = row_hold_ff;
      rcol_in      = rcol_ff;
      rrow_in      = rrow_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func)
                  bau_pkg::FUNC_TRANSLATE: begin
                     res_in = '0;
                     if (in_range) begin
                        res_in.status = bau_pkg::STATUS_OK;
                        res_in.col    = req_col;
                        res_in.row    = req_row;
                        row_hold_in   = req_row;
                        div_start     = 1'b1;
                        state_in      = ST_DIV_COL;
                     end else begin
                        res_in.status = bau_pkg::STATUS_RANGE;
                        state_in      = ST_FINISH;
                     end
                  end
                  bau_pkg::FUNC_NEXT: begin
                     res_in = '0;
                     if (pos.done) begin
                        res_in.status = bau_pkg::STATUS_DONE;
                     end else begin
                        res_in.status    = bau_pkg::STATUS_OK;
                        res_in.col       = pos.col;
                        res_in.row       = pos.row;
                        res_in.block_col = pos.block_col;
                        res_in.block_row = pos.block_row;
                        res_in.cell_idx  = pos.cell_idx;
                        res_in.last      = pos.last_on_step;
                     end
                     state_in = ST_FINISH;
                  end
                  bau_pkg::FUNC_RESTART: begin
                     res_in        = '0;
                     res_in.status = bau_pkg::STATUS_OK;
                     state_in      = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV_COL: begin
            if (div_res.done) begin
               res_in.block_col = div_res.quotient;
               rcol_in          = div_res.remainder;
               div_start        = 1'b1;
               state_in         = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (div_res.done) begin
               res_in.block_row = div_res.quotient;
               rrow_in          = div_res.remainder;
               state_in         = ST_MAC;
            end
         end
         ST_MAC: begin
            res_in.cell_idx = cell_sum[bau_pkg::CELL_W-1:0];
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= bau_pkg::DIM_W'(1);
         height_ff    <= bau_pkg::DIM_W'(1);
         bsize_ff     <= bau_pkg::BLOCK_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bsize_ff     <= bsize_in;
      end
      res_ff      <= res_in;
      rsp_res_ff  <= rsp_res_in;
      row_hold_ff <= row_hold_in;
      rcol_ff     <= rcol_in;
      rrow_ff     <= rrow_in;
   end

   // Pack the response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.cell_idx, rsp_res_ff.block_row, rsp_res_ff.block_col,
                        rsp_res_ff.row, rsp_res_ff.col};
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tlast  = rsp_res_ff.last;

   `BAU_ASSERT(a_div_start_state, clock, reset, div_start |-> ((state_ff == ST_IDLE) || (state_ff == ST_DIV_COL)), "divider started outside a translate")
   `BAU_ASSERT(a_div_done_state, clock, reset, div_res.done |-> ((state_ff == ST_DIV_COL) || (state_ff == ST_DIV_ROW)), "divider result with no one waiting")
   `BAU_ASSERT(a_range_clean, clock, reset, ((state_ff == ST_FINISH) && (res_ff.status != bau_pkg::STATUS_OK)) |-> ((res_ff.col == '0) && (res_ff.cell_idx == '0) && !res_ff.last), "error response carries payload")

endmodule
